### rtl/core/spc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the half-step coil table for the stepper position controller.
package spc_pkg;

    localparam logic [7:0] FULL_TRAVEL = 8'd100;
    localparam logic [7:0] SPU_RESET   = 8'd2;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_OPEN  = 3'd1;
    localparam logic [2:0] MODE_CLOSE = 3'd2;
    localparam logic [2:0] MODE_STOP  = 3'd3;
    localparam logic [2:0] MODE_SET   = 3'd4;

    typedef struct packed {
        logic [7:0]  current_position;
        logic [7:0]  goal_position;
        logic [15:0] steps_left;
        logic        direction_up;
        logic        busy;
        logic [2:0]  phase_index;
        logic [3:0]  coil;
    } state_t;

    typedef struct packed {
        logic [7:0]  goal;
        logic [15:0] steps;
        logic        up;
    } move_t;

    typedef struct packed {
        logic [3:0] coil_drive;
        logic       moving;
        logic [7:0] position;
        logic       limit_stopped;
        logic       move_done;
    } result_t;

    function automatic logic [3:0] half_step_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

### rtl/core/spc_goal.sv
`timescale 1ns / 1ps
// Goal selection and half-step count for a move command.
module spc_goal (
    input  logic [2:0]         mode,
    input  logic signed [31:0] target_value,
    input  logic [7:0]         current_position,
    input  logic [7:0]         steps_per_unit,
    output spc_pkg::move_t     move
);

    logic [7:0] goal;
    logic [7:0] distance;
    logic [7:0] spu;

    always_comb begin
        case (mode)
            spc_pkg::MODE_OPEN:  goal = spc_pkg::FULL_TRAVEL;
            spc_pkg::MODE_CLOSE: goal = 8'd0;
            spc_pkg::MODE_SET: begin
                if (target_value[31]) begin
                    goal = 8'd0;
                end else if (target_value[30:0] > {23'd0, spc_pkg::FULL_TRAVEL}) begin
                    goal = spc_pkg::FULL_TRAVEL;
                end else begin
                    goal = target_value[7:0];
                end
            end
            default:             goal = 8'd0;
        endcase
    end

    assign spu      = (steps_per_unit == 8'd0) ? 8'd1 : steps_per_unit;
    assign distance = (goal > current_position) ? (goal - current_position)
                                                : (current_position - goal);

    assign move.goal  = goal;
    assign move.up    = goal > current_position;
    assign move.steps = {8'd0, distance} * {8'd0, spu};

endmodule

### rtl/core/spc_step.sv
`timescale 1ns / 1ps
// Next-state and flag logic for one transaction of the stepper position controller.
module spc_step (
    input  logic [2:0]      mode,
    input  logic            open_limit_hit,
    input  logic            close_limit_hit,
    input  spc_pkg::state_t cur,
    input  spc_pkg::move_t  move,
    output spc_pkg::state_t nxt,
    output logic            limit_stopped,
    output logic            move_done
);

    always_comb begin
        nxt           = cur;
        limit_stopped = 1'b0;
        move_done     = 1'b0;
        case (mode)
            spc_pkg::MODE_TICK: begin
                if (cur.busy) begin
                    if (cur.steps_left == 16'd0) begin
                        nxt.coil             = 4'h0;
                        nxt.current_position = cur.goal_position;
                        nxt.busy             = 1'b0;
                        move_done            = 1'b1;
                    end else if (cur.direction_up && open_limit_hit) begin
                        nxt.current_position = spc_pkg::FULL_TRAVEL;
                        nxt.coil             = 4'h0;
                        nxt.busy             = 1'b0;
                        limit_stopped        = 1'b1;
                    end else if (!cur.direction_up && close_limit_hit) begin
                        nxt.current_position = 8'd0;
                        nxt.coil             = 4'h0;
                        nxt.busy             = 1'b0;
                        limit_stopped        = 1'b1;
                    end else begin
                        nxt.coil        = spc_pkg::half_step_pattern(cur.phase_index);
                        nxt.phase_index = cur.direction_up ? (cur.phase_index + 3'd1)
                                                           : (cur.phase_index - 3'd1);
                        nxt.steps_left  = cur.steps_left - 16'd1;
                    end
                end
            end
            spc_pkg::MODE_OPEN, spc_pkg::MODE_CLOSE, spc_pkg::MODE_SET: begin
                if (!cur.busy) begin
                    nxt.goal_position = move.goal;
                    nxt.direction_up  = move.up;
                    nxt.steps_left    = move.steps;
                    if (move.steps == 16'd0) begin
                        nxt.coil             = 4'h0;
                        nxt.current_position = move.goal;
                        nxt.busy             = 1'b0;
                        move_done            = 1'b1;
                    end else begin
                        nxt.busy = 1'b1;
                    end
                end
            end
            spc_pkg::MODE_STOP: begin
                nxt.busy = 1'b0;
                nxt.coil = 4'h0;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/core/stepper_position_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the half-step stepper position controller.
//
// The s_ channel carries one command per transaction: a tick (one step period, with the
// two limit switch levels), open, close, stop, or set position with a target value.
// The m_ channel returns exactly one result per command: coil levels, the moving flag,
// the believed position, and the limit-stopped and move-done flags after that command.
// The cfg_ channel writes steps_per_unit and is always ready; write it only while idle.
// A command is captured in an input register and then evaluated against the motor
// state; its result is held in a result register until the receiver takes it.
// The state update is a single pass of short logic with one 8 by 8 multiplier for the
// step count, so one command is accepted in every cycle when the receiver keeps up.
// When the receiver stalls, the result register holds and the input register keeps one
// further command; s_ready then falls until the result is taken.
// Reset clears the position, stops any move, turns the coils off, sets the phase to zero
// and loads steps_per_unit with 2. Both channels come out of reset empty.
module stepper_position_controller_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic signed [31:0] s_target_value,
    input  logic               s_open_limit_hit,
    input  logic               s_close_limit_hit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_coil_drive,
    output logic               m_moving,
    output logic [7:0]         m_position,
    output logic               m_limit_stopped,
    output logic               m_move_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_steps_per_unit
);

    logic               in_valid_reg;
    logic [2:0]         mode_reg;
    logic signed [31:0] target_reg;
    logic               open_hit_reg;
    logic               close_hit_reg;
    logic               m_valid_reg;
    spc_pkg::result_t   result_reg;
    spc_pkg::result_t   result_next;
    spc_pkg::state_t    state_reg;
    spc_pkg::state_t    state_next;
    spc_pkg::move_t     move;
    logic [7:0]         spu_reg;
    logic               out_free;
    logic               proc;
    logic               limit_stopped;
    logic               move_done;

    assign out_free  = !m_valid_reg || m_ready;
    assign proc      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    spc_goal u_goal (
        .mode             (mode_reg),
        .target_value     (target_reg),
        .current_position (state_reg.current_position),
        .steps_per_unit   (spu_reg),
        .move             (move)
    );

    spc_step u_step (
        .mode            (mode_reg),
        .open_limit_hit  (open_hit_reg),
        .close_limit_hit (close_hit_reg),
        .cur             (state_reg),
        .move            (move),
        .nxt             (state_next),
        .limit_stopped   (limit_stopped),
        .move_done       (move_done)
    );

    always_comb begin
        result_next.coil_drive    = state_next.coil;
        result_next.moving        = state_next.busy;
        result_next.position      = state_next.current_position;
        result_next.limit_stopped = limit_stopped;
        result_next.move_done     = move_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
            spu_reg      <= spc_pkg::SPU_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= proc;
            end
            if (proc) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                spu_reg <= cfg_steps_per_unit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg      <= s_mode;
            target_reg    <= s_target_value;
            open_hit_reg  <= s_open_limit_hit;
            close_hit_reg <= s_close_limit_hit;
        end
        if (proc) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_coil_drive    = result_reg.coil_drive;
    assign m_moving        = result_reg.moving;
    assign m_position      = result_reg.position;
    assign m_limit_stopped = result_reg.limit_stopped;
    assign m_move_done     = result_reg.move_done;

`ifndef ASSERT_OFF
    a_coils_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.coil != 4'h0) |-> state_reg.busy)
        else $error("Coils are driven while no move is running.");

    a_position_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.current_position <= spc_pkg::FULL_TRAVEL)
        else $error("Believed position is beyond full travel.");

    a_flags_only_when_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_moving) |-> (!m_limit_stopped && !m_move_done))
        else $error("A move end flag is set on a result that is still moving.");

    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> (m_valid && m_position == state_reg.current_position
                  && m_moving == state_reg.busy))
        else $error("Result does not match the state it was taken from.");
`endif

endmodule
